>>> rtl/mlat_pkg.sv
// shared types and instruction codes for the lui address tracker
`default_nettype none
package mlat_pkg;

	localparam int unsigned RegCount = 32;
	localparam int unsigned RegIdxW  = $clog2(RegCount);
	localparam int unsigned HalfW    = 16;
	localparam int unsigned WordW    = 32;

	localparam logic [WordW-1:0] JR_RA_WORD = 32'h03E0_0008;

	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_ADDI    = 6'h08;
	localparam logic [5:0] OP_ADDIU   = 6'h09;
	localparam logic [5:0] OP_XORI    = 6'h0E;
	localparam logic [5:0] OP_ORI     = 6'h0D;
	localparam logic [5:0] OP_LUI     = 6'h0F;
	localparam logic [5:0] OP_LB      = 6'h20;
	localparam logic [5:0] OP_LWR     = 6'h26;
	localparam logic [5:0] OP_SB      = 6'h28;
	localparam logic [5:0] OP_SW      = 6'h2B;
	localparam logic [5:0] OP_LWC2    = 6'h32;
	localparam logic [5:0] OP_SWC2    = 6'h3A;

	localparam logic [5:0] FN_ADD  = 6'h20;
	localparam logic [5:0] FN_ADDU = 6'h21;

	localparam logic [RegIdxW-1:0] REG_RA = RegIdxW'(31);

	typedef struct packed {
		logic               en;
		logic [RegIdxW-1:0] addr;
		logic [HalfW-1:0]   data;
	} mlat_wr_t;

endpackage
`default_nettype wire

>>> rtl/mips_lui_address_tracker.sv
// lui address tracker top level: decode, tracking state and result register
// an item passes the stage-one and result registers; throughput: one item
// per cycle unless the output stalls; the upper-half store is read when the
// item enters and the value written by the item just ahead is forwarded
// reset clears all valid bits, the return flag and both stage valids
`default_nettype none
module mips_lui_address_tracker
	import mlat_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [WordW-1:0] s_tdata,  // instr
	input  wire logic             s_tuser,  // region_start
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic      [WordW-1:0] m_tdata,  // address
	output logic                  m_tuser   // address_valid
);

	logic               valid_s1;
	logic [WordW-1:0]   instr_s1;
	logic               region_s1;
	logic [RegCount-1:0] track_q;
	logic               after_ret_q;
	mlat_wr_t           fwd_q;
	logic               fwd_valid_q;
	logic [HalfW-1:0]   rd_rs_q, rd_rt_q;

	logic               out_free, advance, in_acc;
	logic [5:0]         op, fn;
	logic [RegIdxW-1:0] rs, rt, rd;
	logic [HalfW-1:0]   imm, half_rs, half_rt;
	logic [RegCount-1:0] track_eff, track_nxt;
	logic               ar_eff, use_op, addr_ok, pass_on;
	logic [WordW-1:0]   hi, sx, addr;
	mlat_wr_t           wr;

	assign out_free = !m_tvalid || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign in_acc   = s_tvalid && s_tready;

	mlat_upper_ram u_ram (
		.clk       (clk),
		.wr        (wr),
		.rd_en     (in_acc),
		.rd_a_addr (s_tdata[25:21]),
		.rd_b_addr (s_tdata[20:16]),
		.rd_a_q    (rd_rs_q),
		.rd_b_q    (rd_rt_q)
	);

	always_comb begin
		op  = instr_s1[31:26];
		fn  = instr_s1[5:0];
		rs  = instr_s1[25:21];
		rt  = instr_s1[20:16];
		rd  = instr_s1[15:11];
		imm = instr_s1[15:0];

		half_rs = (fwd_valid_q && fwd_q.addr == rs) ? fwd_q.data : rd_rs_q;
		half_rt = (fwd_valid_q && fwd_q.addr == rt) ? fwd_q.data : rd_rt_q;

		track_eff = region_s1 ? '0 : track_q;
		ar_eff    = region_s1 ? 1'b0 : after_ret_q;

		use_op = op == OP_ADDIU || op == OP_ORI || op == OP_LWC2 || op == OP_SWC2 ||
			(op >= OP_LB && op <= OP_LWR) || (op >= OP_SB && op <= OP_SW);
		addr_ok = use_op && track_eff[rs];
		hi      = {half_rs, {HalfW{1'b0}}};
		sx      = {{HalfW{imm[HalfW-1]}}, imm};
		addr    = (op == OP_ORI) ? (hi | {{HalfW{1'b0}}, imm}) : (hi + sx);

		pass_on   = (fn == FN_ADD || fn == FN_ADDU) && (track_eff[rs] != track_eff[rt]);
		track_nxt = track_eff;
		wr        = '0;
		if (op == OP_LUI) begin
			track_nxt[rt] = 1'b1;
			wr.en         = 1'b1;
			wr.addr       = rt;
			wr.data       = imm;
		end else if ((op >= OP_ADDI && op <= OP_XORI) || (op >= OP_LB && op <= OP_LWR)) begin
			track_nxt[rt] = 1'b0;
		end else if (op == OP_SPECIAL) begin
			if (pass_on) begin
				track_nxt[rd] = 1'b1;
				wr.en         = 1'b1;
				wr.addr       = rd;
				wr.data       = track_eff[rs] ? half_rs : half_rt;
			end else begin
				track_nxt[rd] = 1'b0;
			end
		end else if (op == OP_JAL) begin
			track_nxt[REG_RA] = 1'b0;
		end
		if (ar_eff) begin
			track_nxt = '0;
		end
		if (!advance) begin
			wr.en = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			track_q     <= '0;
			after_ret_q <= 1'b0;
			fwd_valid_q <= 1'b0;
			m_tvalid    <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				track_q     <= track_nxt;
				after_ret_q <= instr_s1 == JR_RA_WORD;
			end
			if (wr.en) begin
				fwd_valid_q <= 1'b1;
			end
			if (out_free) begin
				m_tvalid <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			instr_s1  <= s_tdata;
			region_s1 <= s_tuser;
		end
		if (wr.en) begin
			fwd_q <= wr;
		end
		if (advance) begin
			m_tuser <= addr_ok;
			m_tdata <= addr_ok ? addr : '0;
		end
	end

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("stage item did not reach the output");

	a_no_addr_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("address nonzero without address_valid");

	a_clear_after_return: assert property (@(posedge clk) disable iff (!arst_n)
		advance && ar_eff |=> track_q == '0)
		else $error("tracking not cleared after return delay slot");

	a_output_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	a_write_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> valid_s1 && out_free)
		else $error("store written without an item leaving stage one");

endmodule
`default_nettype wire

>>> rtl/mlat_upper_ram.sv
// upper-half store: one write port, two registered read ports
`default_nettype none
module mlat_upper_ram
	import mlat_pkg::*;
(
	input  wire logic               clk,
	input  wire mlat_wr_t           wr,
	input  wire logic               rd_en,
	input  wire logic [RegIdxW-1:0] rd_a_addr,
	input  wire logic [RegIdxW-1:0] rd_b_addr,
	output logic      [HalfW-1:0]   rd_a_q,
	output logic      [HalfW-1:0]   rd_b_q
);

	logic [HalfW-1:0] mem [RegCount];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a_q <= mem[rd_a_addr];
			rd_b_q <= mem[rd_b_addr];
		end
	end

endmodule
`default_nettype wire
